// ----- design/pal_pkg.sv -----
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types and command codes for the positional array list.
// ----------------------------------------------------------------------------
`default_nettype none

package pal_pkg;

   localparam int VALUE_W = 32;
   localparam int POS_W   = 7;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_LOCATE = 2'd2;
   localparam logic [1:0] CMD_GET    = 2'd3;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [POS_W-1:0]          pos_type;
   typedef logic [1:0]                cmd_type;

   typedef struct packed {
      logic      shift_up;
      logic      shift_down;
      logic      locate;
      logic      select;
      pos_type   position;
      value_type key;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ----- design/pal_cell.sv -----
// ----------------------------------------------------------------------------
// pal_cell
// One list slot: holds an entry, shifts with its neighbors, flags a hit.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_cell #(
   parameter int SLOT = 1,
   parameter int CW   = 7
) (
   input  wire                    clock,
   input  pal_pkg::cell_ctrl_type ctrl,
   input  wire  [CW-1:0]          count,
   input  pal_pkg::value_type     left_value,
   input  pal_pkg::value_type     right_value,
   output pal_pkg::value_type     value,
   output logic                   hit
);
   import pal_pkg::*;

   value_type value_ff;
   value_type value_in;
   logic      occupied;
   int        pos_int;

   assign pos_int  = int'(ctrl.position);
   assign occupied = (SLOT <= int'(count));

   always_comb begin
      value_in = value_ff;
      if (ctrl.shift_up) begin
         if (SLOT > pos_int) begin
            value_in = left_value;
         end else if (SLOT == pos_int) begin
            value_in = ctrl.key;
         end
      end else if (ctrl.shift_down) begin
         if (SLOT >= pos_int) begin
            value_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
   assign hit   = occupied &&
                  (ctrl.locate ? (value_ff == ctrl.key) : (ctrl.select && SLOT == pos_int));

endmodule

`default_nettype wire

// ----- design/pal_select_tree.sv -----
// ----------------------------------------------------------------------------
// pal_select_tree
// Registered first-hit tree: captures cell hits, reduces one level a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_select_tree #(
   parameter int CAPACITY = 64,
   parameter int IDXW     = 6
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                load,
   input  wire  [CAPACITY-1:0] hits,
   input  pal_pkg::value_type values [CAPACITY],
   output logic               root_valid,
   output logic               root_hit,
   output logic [IDXW-1:0]    root_index,
   output pal_pkg::value_type root_value
);
   import pal_pkg::*;

   localparam int LEAVES = 1 << IDXW;
   localparam int NODES  = 2 * LEAVES;

   logic            hit_ff   [1:NODES-1];
   logic [IDXW-1:0] index_ff [1:NODES-1];
   value_type       value_ff [1:NODES-1];
   logic [IDXW:0]   valid_ff;

   genvar n;
   generate
      for (n = LEAVES; n < NODES; n++) begin : g_leaf
         if (n - LEAVES < CAPACITY) begin : g_used
            always_ff @(posedge clock) begin
               if (load) begin
                  hit_ff[n]   <= hits[n-LEAVES];
                  value_ff[n] <= values[n-LEAVES];
               end
            end
         end else begin : g_pad
            always_ff @(posedge clock) begin
               hit_ff[n]   <= 1'b0;
               value_ff[n] <= '0;
            end
         end
         always_ff @(posedge clock) begin
            index_ff[n] <= IDXW'(n - LEAVES);
         end
      end
      for (n = 1; n < LEAVES; n++) begin : g_node
         always_ff @(posedge clock) begin
            hit_ff[n] <= hit_ff[2*n] | hit_ff[2*n+1];
            if (hit_ff[2*n]) begin
               index_ff[n] <= index_ff[2*n];
               value_ff[n] <= value_ff[2*n];
            end else begin
               index_ff[n] <= index_ff[2*n+1];
               value_ff[n] <= value_ff[2*n+1];
            end
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[IDXW-1:0], load};
      end
   end

   assign root_valid = valid_ff[IDXW];
   assign root_hit   = hit_ff[1];
   assign root_index = index_ff[1];
   assign root_value = value_ff[1];

endmodule

`default_nettype wire

// ----- design/positional_array_list_core.sv -----
// ----------------------------------------------------------------------------
// positional_array_list_core
// Ordered list of signed 32-bit entries with insert, delete, locate and get.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_cmd, req_position and req_item_value with start high; the item
//   is taken at a rising edge where busy is low. Positions are one-based.
//   Every item yields one result, shown on the rsp_ ports for exactly one
//   cycle while rsp_strobe is high. The receiver cannot stall the block.
// Timing:
//   Each entry sits in its own cell, so shifts and compares finish in the
//   accept cycle. The hit of a get, delete or locate then walks a registered
//   select tree of log2(CAPACITY) levels (6 for 64 entries). Busy drops in
//   the cycle in which the result is driven, so the next item can be taken
//   at the edge that closes the result cycle.
// Reset:
//   Synchronous reset empties the list and drops busy and rsp_strobe.
//   Entry contents are not cleared; only occupied slots are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_array_list_core #(
   parameter int CAPACITY = 64
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  pal_pkg::cmd_type   req_cmd,
   input  pal_pkg::pos_type   req_position,
   input  pal_pkg::value_type req_item_value,
   output logic               rsp_strobe,
   output logic               rsp_ok,
   output pal_pkg::value_type rsp_read_value,
   output pal_pkg::pos_type   rsp_found_position,
   output pal_pkg::pos_type   rsp_count,
   output logic               rsp_is_empty
);
   import pal_pkg::*;

   localparam int IDXW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;
   localparam int WTW  = $clog2(IDXW + 1);

   logic [CW-1:0]  count_ff;
   logic [CW-1:0]  count_in;
   logic [WTW-1:0] wait_ff;
   logic [WTW-1:0] wait_in;
   cmd_type        cmd_ff;
   logic           ins_ok_ff;

   logic            accept;
   logic [CMPW-1:0] pos_ext;
   logic [CMPW-1:0] count_ext;
   logic            ins_ok;
   logic            del_ok;
   cell_ctrl_type   ctrl;

   logic [CAPACITY-1:0] hits;
   value_type           values [CAPACITY];

   logic            root_valid;
   logic            root_hit;
   logic [IDXW-1:0] root_index;
   value_type       root_value;

   assign accept    = start && !busy;
   assign pos_ext   = CMPW'(req_position);
   assign count_ext = CMPW'(count_ff);
   assign ins_ok    = (pos_ext != '0) && (pos_ext <= count_ext + CMPW'(1)) &&
                      (count_ext < CMPW'(CAPACITY));
   assign del_ok    = (pos_ext != '0) && (pos_ext <= count_ext);

   always_comb begin
      ctrl.shift_up   = accept && (req_cmd == CMD_INSERT) && ins_ok;
      ctrl.shift_down = accept && (req_cmd == CMD_DELETE) && del_ok;
      ctrl.locate     = (req_cmd == CMD_LOCATE);
      ctrl.select     = (req_cmd == CMD_DELETE) || (req_cmd == CMD_GET);
      ctrl.position   = req_position;
      ctrl.key        = req_item_value;
   end

   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : g_cell
         value_type left_value;
         value_type right_value;
         if (i == 0) begin : g_first
            assign left_value = req_item_value;
         end else begin : g_mid_l
            assign left_value = values[i-1];
         end
         if (i == CAPACITY - 1) begin : g_last
            assign right_value = values[i];
         end else begin : g_mid_r
            assign right_value = values[i+1];
         end
         pal_cell #(
            .SLOT (i + 1),
            .CW   (CW)
         ) u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .count       (count_ff),
            .left_value  (left_value),
            .right_value (right_value),
            .value       (values[i]),
            .hit         (hits[i])
         );
      end
   endgenerate

   pal_select_tree #(
      .CAPACITY (CAPACITY),
      .IDXW     (IDXW)
   ) u_tree (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .hits       (hits),
      .values     (values),
      .root_valid (root_valid),
      .root_hit   (root_hit),
      .root_index (root_index),
      .root_value (root_value)
   );

   always_comb begin
      count_in = count_ff;
      if (ctrl.shift_up) begin
         count_in = count_ff + CW'(1);
      end else if (ctrl.shift_down) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      wait_in = wait_ff;
      if (accept) begin
         wait_in = WTW'(IDXW);
      end else if (wait_ff != '0) begin
         wait_in = wait_ff - WTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         wait_ff  <= '0;
      end else begin
         count_ff <= count_in;
         wait_ff  <= wait_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= req_cmd;
         ins_ok_ff <= ins_ok;
      end
   end

   assign busy = (wait_ff != '0);

   always_comb begin
      rsp_ok             = 1'b0;
      rsp_read_value     = '0;
      rsp_found_position = '0;
      unique case (cmd_ff)
         CMD_INSERT: begin
            rsp_ok = ins_ok_ff;
         end
         CMD_LOCATE: begin
            rsp_ok = 1'b1;
            if (root_hit) begin
               rsp_found_position = POS_W'(root_index) + POS_W'(1);
            end
         end
         CMD_DELETE, CMD_GET: begin
            rsp_ok = root_hit;
            if (root_hit) begin
               rsp_read_value = root_value;
            end
         end
         default: begin
            rsp_ok = 1'b0;
         end
      endcase
   end

   assign rsp_strobe   = root_valid;
   assign rsp_count    = POS_W'(count_ff);
   assign rsp_is_empty = (count_ff == '0);

endmodule

`default_nettype wire

// ----- dv/tb_positional_array_list_core.sv -----
// ----------------------------------------------------------------------------
// tb_positional_array_list_core
// Drives insert, delete, locate and get commands into the list core and
// checks every result against a shadow copy of the list kept in the bench.
// A directed pass covers empty-list access, bad positions, extreme values
// and duplicates. A random pass then fills the list to capacity and drains
// it back to empty several times, with random idle gaps on the sender.
// ----------------------------------------------------------------------------
module tb_positional_array_list_core;
   timeunit 1ns;
   timeprecision 1ps;

   import pal_pkg::*;

   localparam int LIST_DEPTH   = 64;
   localparam int RANDOM_ITEMS = 450;

   typedef struct {
      logic      ok;
      value_type read_value;
      pos_type   found_position;
      pos_type   count;
      logic      is_empty;
   } list_result_type;

   class list_scoreboard;
      value_type       slots[LIST_DEPTH];
      int              list_len;
      list_result_type pending_results[$];
      int unsigned     errors;

      function new();
         list_len = 0;
         errors   = 0;
      endfunction

      function int outstanding();
         return pending_results.size();
      endfunction

      function void note_item(cmd_type cmd, pos_type pos, value_type val);
         list_result_type res;
         int              p;
         int              j;
         res.ok             = 1'b0;
         res.read_value     = '0;
         res.found_position = '0;
         p = int'(pos);
         case (cmd)
            CMD_INSERT: begin
               if (p >= 1 && p <= list_len + 1 && list_len < LIST_DEPTH) begin
                  for (j = list_len; j >= p; j--)
                     slots[j] = slots[j-1];
                  slots[p-1] = val;
                  list_len++;
                  res.ok = 1'b1;
               end
            end
            CMD_DELETE: begin
               if (p >= 1 && p <= list_len) begin
                  res.read_value = slots[p-1];
                  for (j = p; j < list_len; j++)
                     slots[j-1] = slots[j];
                  list_len--;
                  res.ok = 1'b1;
               end
            end
            CMD_LOCATE: begin
               res.ok = 1'b1;
               for (j = 0; j < list_len; j++) begin
                  if (slots[j] == val && res.found_position == '0)
                     res.found_position = pos_type'(j + 1);
               end
            end
            CMD_GET: begin
               if (p >= 1 && p <= list_len) begin
                  res.read_value = slots[p-1];
                  res.ok = 1'b1;
               end
            end
         endcase
         res.count    = pos_type'(list_len);
         res.is_empty = (list_len == 0);
         pending_results.push_back(res);
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH @%0t: %s", $time, msg);
         errors++;
      endtask

      task check_result(logic ok, value_type rd, pos_type fp, pos_type cnt, logic empty);
         list_result_type exp;
         if (pending_results.size() == 0) begin
            report_mismatch("result arrived with no item outstanding");
            return;
         end
         exp = pending_results.pop_front();
         if (ok !== exp.ok)
            report_mismatch($sformatf("ok %b, want %b", ok, exp.ok));
         if (rd !== exp.read_value)
            report_mismatch($sformatf("read_value %0d, want %0d", rd, exp.read_value));
         if (fp !== exp.found_position)
            report_mismatch($sformatf("found_position %0d, want %0d",
                                      fp, exp.found_position));
         if (cnt !== exp.count)
            report_mismatch($sformatf("count %0d, want %0d", cnt, exp.count));
         if (empty !== exp.is_empty)
            report_mismatch($sformatf("is_empty %b, want %b", empty, exp.is_empty));
      endtask
   endclass

   logic      clock          = 1'b0;
   logic      reset          = 1'b1;
   logic      start          = 1'b0;
   logic      busy;
   cmd_type   req_cmd        = CMD_INSERT;
   pos_type   req_position   = '0;
   value_type req_item_value = '0;
   logic      rsp_strobe;
   logic      rsp_ok;
   value_type rsp_read_value;
   pos_type   rsp_found_position;
   pos_type   rsp_count;
   logic      rsp_is_empty;

   bit        no_gap_run = 1'b0;

   list_scoreboard sb = new();

   positional_array_list_core #(.CAPACITY(LIST_DEPTH)) DUT (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_cmd            (req_cmd),
      .req_position       (req_position),
      .req_item_value     (req_item_value),
      .rsp_strobe         (rsp_strobe),
      .rsp_ok             (rsp_ok),
      .rsp_read_value     (rsp_read_value),
      .rsp_found_position (rsp_found_position),
      .rsp_count          (rsp_count),
      .rsp_is_empty       (rsp_is_empty)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1)
         sb.check_result(rsp_ok, rsp_read_value, rsp_found_position, rsp_count,
                         rsp_is_empty);
   end

   task automatic send_item(cmd_type c, pos_type p, value_type v);
      int unsigned gap;
      bit          after_idle;
      gap        = no_gap_run ? 0 : $urandom_range(0, 4);
      after_idle = $urandom_range(0, 1);
      if (gap != 0) begin
         start <= 1'b0;
         if (after_idle) begin
            do @(posedge clock); while (busy !== 1'b0);
         end
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_cmd        <= c;
      req_position   <= p;
      req_item_value <= v;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_item(c, p, v);
   endtask

   initial begin
      int          len;
      int unsigned roll;
      int unsigned linger;
      bit          filling;
      cmd_type     c;
      pos_type     p;
      value_type   v;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_item(CMD_GET,    7'd1,   32'sd0);
      send_item(CMD_DELETE, 7'd1,   32'sd0);
      send_item(CMD_LOCATE, 7'd0,   32'sd0);
      send_item(CMD_INSERT, 7'd0,   32'sd5);
      send_item(CMD_INSERT, 7'd2,   32'sd5);
      send_item(CMD_INSERT, 7'd1,   32'sh7FFF_FFFF);
      send_item(CMD_INSERT, 7'd2,   value_type'(32'h8000_0000));
      send_item(CMD_INSERT, 7'd1,   -32'sd1);
      send_item(CMD_INSERT, 7'd127, 32'sd0);
      send_item(CMD_INSERT, 7'd4,   -32'sd1);
      send_item(CMD_LOCATE, 7'd0,   -32'sd1);
      send_item(CMD_LOCATE, 7'd127, value_type'(32'h8000_0000));
      send_item(CMD_LOCATE, 7'd0,   32'sd12345);
      send_item(CMD_GET,    7'd4,   32'sd0);
      send_item(CMD_GET,    7'd5,   32'sd0);
      send_item(CMD_GET,    7'd0,   32'sd0);
      send_item(CMD_GET,    7'd127, -32'sd1);
      send_item(CMD_DELETE, 7'd5,   32'sd0);
      send_item(CMD_DELETE, 7'd0,   32'sd0);
      send_item(CMD_INSERT, 7'd3,   32'sd0);
      send_item(CMD_DELETE, 7'd2,   32'sd0);
      send_item(CMD_DELETE, 7'd4,   32'sd0);
      send_item(CMD_DELETE, 7'd1,   32'sd0);
      send_item(CMD_GET,    7'd2,   32'sd0);

      filling = 1'b1;
      linger  = 0;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         len = sb.list_len;
         if (i % 37 == 0)
            no_gap_run = ($urandom_range(0, 2) == 0);

         // hold at full or empty for a while, then turn around
         if ((filling && len == LIST_DEPTH) || (!filling && len == 0))
            linger++;
         if (linger > (filling ? 12 : 6)) begin
            filling = !filling;
            linger  = 0;
         end

         roll = $urandom_range(0, 99);
         if (roll < (filling ? 55 : 15))
            c = CMD_INSERT;
         else if (roll < 65)
            c = CMD_DELETE;
         else if (roll < 82)
            c = CMD_LOCATE;
         else
            c = CMD_GET;

         roll = $urandom_range(0, 99);
         if (roll < 12 || (len == 0 && c != CMD_INSERT))
            p = pos_type'($urandom_range(0, 127));
         else if (c == CMD_INSERT)
            p = (roll < 20) ? pos_type'(len + 1) :
                (roll < 28) ? 7'd1 : pos_type'($urandom_range(1, len + 1));
         else
            p = (roll < 20) ? pos_type'(len) :
                (roll < 28) ? 7'd1 : pos_type'($urandom_range(1, len));

         roll = $urandom_range(0, 99);
         if (roll < 40)
            v = value_type'($urandom);
         else if (roll < 60)
            v = value_type'($urandom_range(0, 15)) - 32'sd8;
         else if (roll < 70) begin
            case ($urandom_range(0, 3))
               0: v = value_type'(32'h8000_0000);
               1: v = 32'sh7FFF_FFFF;
               2: v = 32'sd0;
               default: v = -32'sd1;
            endcase
         end else if (len > 0)
            v = sb.slots[$urandom_range(0, len - 1)];
         else
            v = value_type'($urandom);

         send_item(c, p, v);
      end
      start <= 1'b0;

      while (sb.outstanding() > 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      if (sb.errors == 0)
         $display("tb_positional_array_list_core passed");
      else
         $display("tb_positional_array_list_core failed");
      $finish;
   end

   initial begin
      #400000;
      $display("tb_positional_array_list_core failed");
      $finish;
   end

endmodule
